[design/i2crts_pkg.sv]
// i2crts_pkg: shared types and codes for the i2c register transaction sequencer
// no dependencies; used by i2crts_step and the top level

package i2crts_pkg;

   // request op codes
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_GC    = 2'd2;
   localparam logic [1:0] OP_DONE  = 2'd3;

   // transaction phases
   localparam logic [3:0] PH_IDLE    = 4'd0;
   localparam logic [3:0] PH_ADDR_W  = 4'd1;
   localparam logic [3:0] PH_REG1    = 4'd2;
   localparam logic [3:0] PH_REG2    = 4'd3;
   localparam logic [3:0] PH_ADDR_R  = 4'd4;
   localparam logic [3:0] PH_RX0     = 4'd5;
   localparam logic [3:0] PH_RX1     = 4'd6;
   localparam logic [3:0] PH_DATA1   = 4'd7;
   localparam logic [3:0] PH_DATA2   = 4'd8;
   localparam logic [3:0] PH_GC_ADDR = 4'd9;
   localparam logic [3:0] PH_GC_CMD  = 4'd10;

   // transaction kinds
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_GC    = 2'd2;

   // result status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NACK    = 3'd1;
   localparam logic [2:0] ST_ARBLOST = 3'd2;
   localparam logic [2:0] ST_UNKNOWN = 3'd3;
   localparam logic [2:0] ST_OOT     = 3'd4;

   // general call bytes
   localparam logic [7:0] GC_ADDR      = 8'h00;
   localparam logic [7:0] GC_RESET_CMD = 8'h06;

   typedef struct packed {
      logic [1:0] op;
      logic [6:0] dev_addr;
      logic [7:0] reg_first;
      logic [7:0] reg_second;
      logic       has_second;
      logic [7:0] data_first;
      logic [7:0] data_second;
      logic       done_rxack;
      logic       done_arblost;
      logic [7:0] done_byte;
   } req_type;

   typedef struct packed {
      logic [3:0] phase;
      logic [1:0] txn_kind;
      logic [6:0] dev_addr;
      logic [7:0] reg_first;
      logic [7:0] reg_second;
      logic       has_second;
      logic [7:0] data_first;
      logic [7:0] data_second;
      logic [7:0] first_rx_byte;
   } seq_state_type;

   typedef struct packed {
      logic        is_result;
      logic        cmd_read;
      logic        cmd_start;
      logic        cmd_stop;
      logic        cmd_nack;
      logic [7:0]  cmd_byte;
      logic [2:0]  status_code;
      logic [15:0] read_value;
      logic        err_rxack;
      logic        err_arblost;
   } rsp_type;

endpackage

[design/i2crts_step.sv]
// i2crts_step: next-state and response logic for one accepted item
// depends on i2crts_pkg

module i2crts_step import i2crts_pkg::*; (
   input  req_type       req,
   input  seq_state_type cur,
   output seq_state_type nxt,
   output rsp_type       rsp
);

   logic is_rx;
   logic fail;

   always_comb begin
      nxt   = cur;
      rsp   = '0;
      is_rx = (cur.phase == PH_RX0) || (cur.phase == PH_RX1);
      fail  = is_rx ? req.done_arblost : (req.done_rxack | req.done_arblost);

      if (req.op != OP_DONE) begin
         if (cur.phase != PH_IDLE) begin
            rsp.is_result   = 1'b1;
            rsp.status_code = ST_OOT;
         end else begin
            nxt.dev_addr    = req.dev_addr;
            nxt.reg_first   = req.reg_first;
            nxt.reg_second  = req.reg_second;
            nxt.has_second  = req.has_second;
            nxt.data_first  = req.data_first;
            nxt.data_second = req.data_second;
            rsp.cmd_start   = 1'b1;
            if (req.op == OP_GC) begin
               nxt.txn_kind = KIND_GC;
               nxt.phase    = PH_GC_ADDR;
               rsp.cmd_byte = GC_ADDR;
            end else begin
               nxt.txn_kind = (req.op == OP_READ) ? KIND_READ : KIND_WRITE;
               nxt.phase    = PH_ADDR_W;
               rsp.cmd_byte = {req.dev_addr, 1'b0};
            end
         end
      end else if (cur.phase == PH_IDLE || cur.phase > PH_GC_CMD) begin
         nxt.phase       = PH_IDLE;
         rsp.is_result   = 1'b1;
         rsp.status_code = ST_OOT;
      end else if (fail) begin
         nxt.phase       = PH_IDLE;
         rsp.is_result   = 1'b1;
         // nack wins over arbitration lost
         rsp.status_code = req.done_rxack ? ST_NACK :
                           (req.done_arblost ? ST_ARBLOST : ST_UNKNOWN);
         rsp.err_rxack   = req.done_rxack;
         rsp.err_arblost = req.done_arblost;
      end else begin
         unique case (cur.phase)
            PH_ADDR_W: begin
               nxt.phase    = PH_REG1;
               rsp.cmd_byte = cur.reg_first;
            end
            PH_REG1, PH_REG2: begin
               if (cur.phase == PH_REG1 && cur.has_second) begin
                  nxt.phase    = PH_REG2;
                  rsp.cmd_byte = cur.reg_second;
               end else if (cur.txn_kind == KIND_READ) begin
                  // repeated start with the read address
                  nxt.phase     = PH_ADDR_R;
                  rsp.cmd_start = 1'b1;
                  rsp.cmd_byte  = {cur.dev_addr, 1'b1};
               end else begin
                  nxt.phase    = PH_DATA1;
                  rsp.cmd_byte = cur.data_first;
               end
            end
            PH_ADDR_R: begin
               nxt.phase    = PH_RX0;
               rsp.cmd_read = 1'b1;
            end
            PH_RX0: begin
               nxt.first_rx_byte = req.done_byte;
               nxt.phase         = PH_RX1;
               rsp.cmd_read      = 1'b1;
               rsp.cmd_stop      = 1'b1;
               rsp.cmd_nack      = 1'b1;
            end
            PH_RX1: begin
               nxt.phase      = PH_IDLE;
               rsp.is_result  = 1'b1;
               rsp.read_value = {cur.first_rx_byte, req.done_byte};
            end
            PH_DATA1: begin
               nxt.phase    = PH_DATA2;
               rsp.cmd_stop = 1'b1;
               rsp.cmd_byte = cur.data_second;
            end
            PH_GC_ADDR: begin
               nxt.phase    = PH_GC_CMD;
               rsp.cmd_stop = 1'b1;
               rsp.cmd_byte = GC_RESET_CMD;
            end
            default: begin
               // last byte of a write or general call finished
               nxt.phase     = PH_IDLE;
               rsp.is_result = 1'b1;
            end
         endcase
      end
   end

endmodule

[design/i2c_register_transaction_sequencer.sv]
// i2c_register_transaction_sequencer: top level, state and response registers
// depends on i2crts_pkg and i2crts_step
//
//   channel | direction | handshake              | payload
//   req_    | in        | req_valid / req_ready  | op, address, pointer, data, done flags
//   rsp_    | out       | rsp_valid / rsp_ready  | command or final result
//
// a transfer on req_ updates the transaction state and loads the response
// register at the same edge; one item per cycle sustained while rsp_ready is high.
// req_ready is high whenever the response register is empty or being drained,
// so a stalled rsp_ side holds off new requests only while a response waits.
// synchronous reset returns the sequencer to idle with all saved fields zero.

module i2c_register_transaction_sequencer import i2crts_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [6:0]  req_dev_addr,
   input  logic [7:0]  req_reg_first,
   input  logic [7:0]  req_reg_second,
   input  logic        req_has_second,
   input  logic [7:0]  req_data_first,
   input  logic [7:0]  req_data_second,
   input  logic        req_done_rxack,
   input  logic        req_done_arblost,
   input  logic [7:0]  req_done_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_is_result,
   output logic        rsp_cmd_read,
   output logic        rsp_cmd_start,
   output logic        rsp_cmd_stop,
   output logic        rsp_cmd_nack,
   output logic [7:0]  rsp_cmd_byte,
   output logic [2:0]  rsp_status_code,
   output logic [15:0] rsp_read_value,
   output logic        rsp_err_rxack,
   output logic        rsp_err_arblost
);

   req_type       req;
   seq_state_type state_ff;
   seq_state_type state_in;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;
   logic          rsp_valid_ff;
   logic          req_fire;

   assign req = '{op: req_op, dev_addr: req_dev_addr, reg_first: req_reg_first,
                  reg_second: req_reg_second, has_second: req_has_second,
                  data_first: req_data_first, data_second: req_data_second,
                  done_rxack: req_done_rxack, done_arblost: req_done_arblost,
                  done_byte: req_done_byte};

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   i2crts_step u_step (
      .req (req),
      .cur (state_ff),
      .nxt (state_in),
      .rsp (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            state_ff <= state_in;
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload register, loaded on every request transfer
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_result   = rsp_ff.is_result;
   assign rsp_cmd_read    = rsp_ff.cmd_read;
   assign rsp_cmd_start   = rsp_ff.cmd_start;
   assign rsp_cmd_stop    = rsp_ff.cmd_stop;
   assign rsp_cmd_nack    = rsp_ff.cmd_nack;
   assign rsp_cmd_byte    = rsp_ff.cmd_byte;
   assign rsp_status_code = rsp_ff.status_code;
   assign rsp_read_value  = rsp_ff.read_value;
   assign rsp_err_rxack   = rsp_ff.err_rxack;
   assign rsp_err_arblost = rsp_ff.err_arblost;

   // every accepted item produces a response in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("no response after request transfer");

   // a pending byte command always belongs to a running transaction
   a_cmd_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.is_result |-> state_ff.phase != PH_IDLE)
      else $error("byte command pending while idle");

   // a request taken while idle starts a transaction
   a_req_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_op != OP_DONE && state_ff.phase == PH_IDLE
      |=> state_ff.phase != PH_IDLE && !rsp_ff.is_result)
      else $error("request did not start a transaction");

   // the sequencer never enters an unused phase encoding
   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase <= PH_GC_CMD)
      else $error("phase outside legal range");

endmodule
